/* rtl/ntre_pkg.sv */
// Package for the note table range editor: command codes, entry layout
// and the sort key helper. No dependencies.
package ntre_pkg;

  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_CLEAR    = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_TRUNCATE = 2'd3
  } mode_e;

  localparam int unsigned TickW = 24;
  localparam int unsigned ChanW = 8;
  localparam int unsigned KeyW  = 7;
  localparam int unsigned VolW  = 7;
  localparam int unsigned SortW = ChanW + TickW + KeyW;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [TickW-1:0] start;
    logic [TickW-1:0] length;
    logic [KeyW-1:0]  key;
    logic [VolW-1:0]  volume;
  } note_t;

  function automatic logic [SortW-1:0] sort_key(input note_t n);
    sort_key = {n.chan, n.start, n.key};
  endfunction

endpackage

/* rtl/note_table_range_editor_unit.sv */
// Top level of the note table range editor: table memory, sequencer and
// output register. Uses ntre_pkg and ntre_cmp.
// Add and clear finish without leaving the idle state; a rejected add also
// passes through the output state and waits out any output stall. Truncate
// walks the table once. Remove runs an insertion sort over the table, then
// a walk that reports each removed note and waits out any output stall.
// All of it goes through one compare unit and one table read per cycle.
// stall_o is high whenever the sequencer is not idle.
module note_table_range_editor_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  chan_i,
  input  logic        all_channels_i,
  input  logic [23:0] start_tick_i,
  input  logic [23:0] end_tick_i,
  input  logic [23:0] note_length_i,
  input  logic [6:0]  note_key_i,
  input  logic [6:0]  note_volume_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        status_o,
  output logic [7:0]  out_chan_o,
  output logic [23:0] out_start_o,
  output logic [23:0] out_length_o,
  output logic [6:0]  out_key_o,
  output logic [6:0]  out_volume_o,
  output logic        last_o
);
  import ntre_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SORT_RD, S_SORT_CMP, S_SORT_WR, S_SCAN_RD, S_SCAN, S_OUT, S_LAST, S_DONE
  } state_e;

  note_t mem_q [CAPACITY];
  note_t rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  note_t         wr_data;

  state_e        state_q;
  logic [CW-1:0] count_q, i_q, j_q, w_q;
  logic [1:0]    mode_q;
  logic [7:0]    chan_q;
  logic          all_q;
  logic [23:0]   lo_q, hi_q;
  note_t         hold_q;
  logic          found_q;
  note_t         pend_q;
  logic          pend_v_q;

  logic          ov_q, ost_q, olast_q;
  note_t         on_q;

  logic a_gt, c_hit, in_rng, s_ge, e_gt;

  ntre_cmp u_cmp (
    .a_i(rd_q), .b_i(hold_q), .lo_i(lo_q), .hi_i(hi_q), .chan_i(chan_q),
    .all_i(all_q), .a_gt_b_o(a_gt), .chan_hit_o(c_hit), .in_range_o(in_rng),
    .start_ge_o(s_ge), .end_gt_o(e_gt)
  );

  logic out_free;
  logic out_load;
  assign out_free = !ov_q || !stall_i;
  assign out_load = (state_q == S_OUT || state_q == S_LAST) && out_free;
  assign stall_o  = (state_q != S_IDLE);

  always_comb begin
    rd_addr = AW'(i_q);
    if (state_q == S_SORT_CMP || state_q == S_SORT_WR) rd_addr = AW'(j_q - 1'b1);
    if (state_q == S_SORT_CMP && found_q && j_q != '0 && a_gt) rd_addr = AW'(j_q - 2'd2);
    wr_en   = 1'b0;
    wr_addr = AW'(j_q);
    wr_data = rd_q;
    case (state_q)
      S_IDLE: begin
        wr_en   = valid_i && (mode_e'(mode_i) == MODE_ADD) && (count_q < CW'(CAPACITY));
        wr_addr = AW'(count_q);
        wr_data = '{chan_i, start_tick_i, note_length_i, note_key_i, note_volume_i};
      end
      S_SORT_CMP: begin
        wr_en   = found_q && (j_q != '0) && a_gt;
        wr_addr = AW'(j_q);
        wr_data = rd_q;
      end
      S_SORT_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(j_q);
        wr_data = hold_q;
      end
      S_SCAN: begin
        wr_addr = AW'(w_q);
        if (mode_q == MODE_REMOVE) begin
          wr_en = !(c_hit && in_rng);
        end else begin
          wr_en = !(c_hit && s_ge);
          if (c_hit && e_gt && !s_ge) wr_data.length = lo_q - rd_q.start;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; i_q <= '0; j_q <= '0; w_q <= '0;
      mode_q <= '0; chan_q <= '0; all_q <= 1'b0; lo_q <= '0; hi_q <= '0;
      hold_q <= '0; found_q <= 1'b0; pend_q <= '0; pend_v_q <= 1'b0;
      ov_q <= 1'b0; ost_q <= 1'b0; olast_q <= 1'b0; on_q <= '0;
    end else begin
      if (out_load) ov_q <= 1'b1;
      else if (!stall_i) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (valid_i) begin
          mode_q <= mode_i; chan_q <= chan_i; all_q <= all_channels_i;
          lo_q <= start_tick_i; hi_q <= end_tick_i;
          i_q <= '0; w_q <= '0; found_q <= 1'b0; pend_v_q <= 1'b0;
          unique case (mode_e'(mode_i))
            MODE_ADD: begin
              if (count_q < CW'(CAPACITY)) count_q <= count_q + 1'b1;
              else state_q <= S_OUT;
            end
            MODE_CLEAR: count_q <= '0;
            MODE_REMOVE: begin
              if (start_tick_i > end_tick_i) begin
                lo_q <= end_tick_i; hi_q <= start_tick_i;
              end
              i_q <= CW'(1);
              state_q <= S_SORT_RD;
            end
            default: state_q <= S_SCAN_RD;
          endcase
        end
        S_SORT_RD: begin
          if (i_q >= count_q) begin
            i_q <= '0; state_q <= S_SCAN_RD;
          end else begin
            j_q <= i_q; state_q <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (j_q == i_q && !found_q) begin
            hold_q <= rd_q; found_q <= 1'b1;
          end else if (j_q != '0 && a_gt) begin
            j_q <= j_q - 1'b1;
          end else state_q <= S_SORT_WR;
        end
        S_SORT_WR: begin
          found_q <= 1'b0; i_q <= i_q + 1'b1; state_q <= S_SORT_RD;
        end
        S_SCAN_RD: state_q <= (i_q < count_q) ? S_SCAN : S_DONE;
        S_SCAN: begin
          if (wr_en) w_q <= w_q + 1'b1;
          if (mode_q == MODE_REMOVE && c_hit && in_rng) begin
            if (pend_v_q) begin
              hold_q <= rd_q;
              state_q <= S_OUT;
            end else begin
              pend_q <= rd_q; pend_v_q <= 1'b1;
              state_q <= S_SCAN_RD;
            end
          end else state_q <= S_SCAN_RD;
          i_q <= i_q + 1'b1;
        end
        S_OUT: if (out_free) begin
          if (mode_q == MODE_ADD) begin
            on_q <= '0; ost_q <= 1'b1; olast_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            on_q <= pend_q; ost_q <= 1'b0; olast_q <= 1'b0;
            pend_q <= hold_q;
            state_q <= S_SCAN_RD;
          end
        end
        S_LAST: if (out_free) begin
          on_q <= pend_q; ost_q <= 1'b0; olast_q <= 1'b1;
          pend_v_q <= 1'b0; state_q <= S_IDLE;
        end
        S_DONE: begin
          count_q <= w_q;
          state_q <= pend_v_q ? S_LAST : S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign valid_o      = ov_q;
  assign status_o     = ost_q;
  assign out_chan_o   = on_q.chan;
  assign out_start_o  = on_q.start;
  assign out_length_o = on_q.length;
  assign out_key_o    = on_q.key;
  assign out_volume_o = on_q.volume;
  assign last_o       = olast_q;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY)) else $error("note count above capacity");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> stall_o) else $error("accepting while busy");
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o) |-> last_o) else $error("reject not last");
`endif
endmodule

/* rtl/ntre_cmp.sv */
// Shared compare unit of the note table editor: one entry against the
// command operands and against a held entry's sort key. Uses ntre_pkg.
module ntre_cmp (
  input  ntre_pkg::note_t          a_i,
  input  ntre_pkg::note_t          b_i,
  input  logic [ntre_pkg::TickW-1:0] lo_i,
  input  logic [ntre_pkg::TickW-1:0] hi_i,
  input  logic [ntre_pkg::ChanW-1:0] chan_i,
  input  logic                     all_i,
  output logic                     a_gt_b_o,
  output logic                     chan_hit_o,
  output logic                     in_range_o,
  output logic                     start_ge_o,
  output logic                     end_gt_o
);
  import ntre_pkg::*;
  logic [TickW:0] a_end;
  assign a_end      = {1'b0, a_i.start} + {1'b0, a_i.length};
  assign a_gt_b_o   = sort_key(a_i) > sort_key(b_i);
  assign chan_hit_o = all_i || (a_i.chan == chan_i);
  assign in_range_o = (a_i.start >= lo_i) && (a_end <= {1'b0, hi_i});
  assign start_ge_o = a_i.start >= lo_i;
  assign end_gt_o   = a_end > {1'b0, lo_i};
endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for note_table_range_editor_unit: drives add, clear,
// remove-range and truncate commands and checks removed-note and rejected-add reports.
// Depends on ntre_pkg and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ntre_pkg::*;

  localparam int unsigned Cap = 64;
  localparam int unsigned IdleLimit = 200000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  chan;
    logic        all_ch;
    logic [23:0] t0;
    logic [23:0] t1;
    logic [23:0] len;
    logic [6:0]  key;
    logic [6:0]  vol;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  chan;
    logic [23:0] start;
    logic [23:0] length;
    logic [6:0]  key;
    logic [6:0]  volume;
    logic        last;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [1:0]  mode_i = '0;
  logic [7:0]  chan_i = '0;
  logic        all_channels_i = 1'b0;
  logic [23:0] start_tick_i = '0;
  logic [23:0] end_tick_i = '0;
  logic [23:0] note_length_i = '0;
  logic [6:0]  note_key_i = '0;
  logic [6:0]  note_volume_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic        status_o;
  logic [7:0]  out_chan_o;
  logic [23:0] out_start_o;
  logic [23:0] out_length_o;
  logic [6:0]  out_key_o;
  logic [6:0]  out_volume_o;
  logic        last_o;

  note_table_range_editor_unit #(.CAPACITY(Cap)) u_dut (.*);

  always #5 clk_i = ~clk_i;

  cmd_t    pending_cmds[$];
  report_t expected_reports[$];
  note_t   notes[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      hold_off = 1'b0;
  int      burst_left = 0;
  int      gap_left = 0;

  function automatic logic [SortW-1:0] order_of(note_t n);
    return {n.chan, n.start, n.key};
  endfunction

  function automatic void queue_cmd(cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic void predict_command(cmd_t c);
    note_t   n;
    note_t   kept[$];
    report_t r;
    logic [23:0] lo, hi;
    logic [24:0] fin;
    int j;
    case (mode_e'(c.mode))
      MODE_ADD: begin
        if (notes.size() >= Cap) begin
          r = '0;
          r.status = 1'b1;
          r.last = 1'b1;
          expected_reports = {expected_reports, r};
        end else begin
          n.chan = c.chan; n.start = c.t0; n.length = c.len;
          n.key = c.key; n.volume = c.vol;
          notes = {notes, n};
        end
      end
      MODE_CLEAR: notes.delete();
      MODE_REMOVE: begin
        lo = c.t0; hi = c.t1;
        if (lo > hi) begin
          lo = c.t1; hi = c.t0;
        end
        for (int i = 1; i < notes.size(); i++) begin
          n = notes[i];
          j = i;
          while (j > 0 && order_of(notes[j-1]) > order_of(n)) begin
            notes[j] = notes[j-1];
            j--;
          end
          notes[j] = n;
        end
        j = 0;
        foreach (notes[i]) begin
          n = notes[i];
          fin = {1'b0, n.start} + {1'b0, n.length};
          if ((c.all_ch || n.chan == c.chan) && n.start >= lo && fin <= {1'b0, hi}) begin
            r.status = 1'b0; r.chan = n.chan; r.start = n.start;
            r.length = n.length; r.key = n.key; r.volume = n.volume; r.last = 1'b0;
            expected_reports = {expected_reports, r};
            j++;
          end else begin
            kept = {kept, n};
          end
        end
        if (j > 0) expected_reports[$].last = 1'b1;
        notes = kept;
      end
      default: begin
        foreach (notes[i]) begin
          n = notes[i];
          if (c.all_ch || n.chan == c.chan) begin
            if (n.start >= c.t0) continue;
            if ({1'b0, n.start} + {1'b0, n.length} > {1'b0, c.t0}) n.length = c.t0 - n.start;
          end
          kept = {kept, n};
        end
        notes = kept;
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) predict_command(pending_cmds.pop_front());
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!(valid_i && stall_o) && (pending_cmds.size() == 0 || hold_off)) begin
        valid_i <= 1'b0;
      end else if (!(valid_i && stall_o)) begin
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
          valid_i <= 1'b1;
          {mode_i, chan_i, all_channels_i, start_tick_i, end_tick_i, note_length_i,
           note_key_i, note_volume_i} <= pending_cmds[0];
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          valid_i <= 1'b0;
        end else begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          valid_i <= 1'b0;
        end
      end
      stall_i <= ($urandom_range(0, 15) < 4) && ($urandom_range(0, 7) != 0);
    end
  end

  always @(posedge clk_i) begin
    report_t got;
    report_t exp;
    if (rst_ni && valid_o && !stall_i) begin
      got = {status_o, out_chan_o, out_start_o, out_length_o, out_key_o, out_volume_o, last_o};
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %h", got);
      end else begin
        exp = expected_reports.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report mismatch: expected %h got %h", exp, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic cmd_t random_cmd(int fill_bias);
    cmd_t c;
    int   r;
    c.chan = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    c.all_ch = ($urandom_range(0, 3) == 0);
    c.t0 = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
    c.t1 = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
    c.len = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 600));
    c.key = 7'($urandom);
    c.vol = 7'($urandom);
    r = $urandom_range(0, 99);
    if (r < fill_bias) c.mode = MODE_ADD;
    else if (r < fill_bias + 4) c.mode = MODE_CLEAR;
    else if (r < 90) c.mode = MODE_REMOVE;
    else c.mode = MODE_TRUNCATE;
    return c;
  endfunction

  function automatic cmd_t make_cmd(mode_e m, logic [7:0] ch, logic all_ch, logic [23:0] t0,
                                    logic [23:0] t1, logic [23:0] len, logic [6:0] key,
                                    logic [6:0] vol);
    cmd_t c;
    c.mode = m; c.chan = ch; c.all_ch = all_ch; c.t0 = t0; c.t1 = t1;
    c.len = len; c.key = key; c.vol = vol;
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || valid_i || expected_reports.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    cmd_t c;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_cmd(make_cmd(MODE_ADD, 8'hFF, 1'b0, 24'hFFFFFF, 24'h0, 24'hFFFFFF, 7'h7F, 7'h7F));
    queue_cmd(make_cmd(MODE_ADD, 8'h00, 1'b1, 24'h0, 24'hFFFFFF, 24'h0, 7'h0, 7'h0));
    queue_cmd(make_cmd(MODE_ADD, 8'h00, 1'b0, 24'h10, 24'h0, 24'h5, 7'h3, 7'h1));
    queue_cmd(make_cmd(MODE_ADD, 8'h00, 1'b0, 24'h10, 24'h0, 24'h5, 7'h3, 7'h2));
    queue_cmd(make_cmd(MODE_ADD, 8'h00, 1'b0, 24'h10, 24'h0, 24'h5, 7'h1, 7'h3));
    queue_cmd(make_cmd(MODE_REMOVE, 8'h00, 1'b0, 24'h40, 24'h0, 24'h0, 7'h0, 7'h0));
    queue_cmd(make_cmd(MODE_REMOVE, 8'h00, 1'b1, 24'h0, 24'hFFFFFF, 24'h0, 7'h0, 7'h0));
    queue_cmd(make_cmd(MODE_REMOVE, 8'hFF, 1'b0, 24'h0, 24'hFFFFFF, 24'h0, 7'h0, 7'h0));
    queue_cmd(make_cmd(MODE_ADD, 8'h05, 1'b0, 24'd100, 24'h0, 24'd50, 7'h9, 7'h9));
    queue_cmd(make_cmd(MODE_ADD, 8'h05, 1'b0, 24'd200, 24'h0, 24'd10, 7'h9, 7'h9));
    queue_cmd(make_cmd(MODE_ADD, 8'h06, 1'b0, 24'd120, 24'h0, 24'd10, 7'h9, 7'h9));
    queue_cmd(make_cmd(MODE_TRUNCATE, 8'h05, 1'b0, 24'd120, 24'h0, 24'h0, 7'h0, 7'h0));
    queue_cmd(make_cmd(MODE_TRUNCATE, 8'h00, 1'b1, 24'd0, 24'h0, 24'h0, 7'h0, 7'h0));
    queue_cmd(make_cmd(MODE_CLEAR, 8'h00, 1'b0, 24'h0, 24'h0, 24'h0, 7'h0, 7'h0));
    for (int i = 0; i < Cap + 2; i++) begin
      c = random_cmd(100);
      c.chan = 8'(i % 3);
      queue_cmd(c);
    end
    queue_cmd(make_cmd(MODE_REMOVE, 8'h00, 1'b1, 24'hFFFFFF, 24'h0, 24'h0, 7'h0, 7'h0));
    wait_drained();
    hold_off = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_off = 1'b0;
    for (int i = 0; i < 200; i++) queue_cmd(random_cmd(70));
    queue_cmd(make_cmd(MODE_CLEAR, 8'h00, 1'b0, 24'h0, 24'h0, 24'h0, 7'h0, 7'h0));
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
